>>> rtl/lst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg
// Shared constants, codes and types of the loop sample trigger.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int LEVEL_BITS  = 16;
  localparam int COUNT_BITS  = 32;
  localparam int ITER_BITS   = 32;
  localparam int TIME_BITS   = 48;
  localparam int PERIOD_BITS = 16;
  localparam int TICKS_BITS  = 32;
  localparam int CFG_BITS    = 32;
  localparam int DIV_STEPS   = COUNT_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    EV_LOOP_BEGIN = 2'd0,
    EV_LOOP_END   = 2'd1,
    EV_ITER_BEGIN = 2'd2,
    EV_ITER_END   = 2'd3
  } ev_t;

  typedef enum logic {
    REG_ITER_PERIOD = 1'b0,
    REG_TIME_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_CHECK,
    ST_FIRE
  } state_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic sample;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    ev_t  func;
    logic at_watched;
    logic begin_fire;
    logic time_fire;
    logic period_on;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/lst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_ctrl
// Sequencer that takes one request at a time, runs the period remainder and
// loads the result register.
// ----------------------------------------------------------------------------
module lst_ctrl
  import lst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        case (status.func)
          EV_LOOP_BEGIN: begin
            if (status.begin_fire) begin
              state_nxt = ST_FIRE;
            end else begin
              cmd.update = 1'b1;
            end
          end
          EV_LOOP_END: begin
            if (status.at_watched) begin
              state_nxt = ST_FIRE;
            end else begin
              cmd.update = 1'b1;
            end
          end
          EV_ITER_BEGIN: begin
            cmd.update = 1'b1;
          end
          EV_ITER_END: begin
            if (status.at_watched) begin
              if (status.time_fire) begin
                state_nxt = ST_FIRE;
              end else if (status.period_on) begin
                cmd.div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.rem_zero ? ST_FIRE : ST_IDLE;
      end
      ST_FIRE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.sample = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.sample | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/lst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_dp
// Level tracking, iteration count, elapsed time check, serial remainder and
// result register of the loop sample trigger.
// ----------------------------------------------------------------------------
module lst_dp
  import lst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_wdata,
  input  wire logic [1:0]            in_func,
  input  wire logic                  in_is_target,
  input  wire logic signed [ITER_BITS-1:0] in_iteration_value,
  input  wire logic [TIME_BITS-1:0]  in_timestamp,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic [COUNT_BITS-1:0]      out_iteration_count,
  output logic signed [ITER_BITS-1:0] out_first_iteration,
  output logic                       out_has_first
);

  logic [PERIOD_BITS-1:0] iter_period_r;
  logic [TICKS_BITS-1:0]  time_period_r;
  logic [LEVEL_BITS-1:0]  nest_r, nest_nxt;
  logic [LEVEL_BITS-1:0]  watched_r, watched_nxt;
  logic [COUNT_BITS-1:0]  counter_r, counter_nxt;
  logic [ITER_BITS-1:0]   start_r, start_nxt;
  logic [TIME_BITS-1:0]   last_time_r, last_time_nxt;

  ev_t                    func_r;
  logic                   target_r;
  logic [ITER_BITS-1:0]   value_r;
  logic [TIME_BITS-1:0]   ts_r;

  logic [PERIOD_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0]  quo_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [PERIOD_BITS:0]   div_shift;
  logic [PERIOD_BITS:0]   div_diff;

  logic [COUNT_BITS-1:0]  out_count_r;
  logic [ITER_BITS-1:0]   out_first_r;
  logic                   out_has_r;

  logic [TIME_BITS-1:0]   elapsed;
  logic                   at_watched;
  logic                   start_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_period_r <= '0;
      time_period_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ITER_PERIOD: iter_period_r <= cfg_wdata[PERIOD_BITS-1:0];
        REG_TIME_PERIOD: time_period_r <= cfg_wdata[TICKS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign at_watched = (nest_r == watched_r);
  assign start_ok   = ~start_r[ITER_BITS-1];
  assign elapsed    = ts_r - last_time_r;

  always_comb begin
    nest_nxt      = nest_r;
    watched_nxt   = watched_r;
    counter_nxt   = counter_r;
    start_nxt     = start_r;
    last_time_nxt = last_time_r;
    if (cmd.update || cmd.sample) begin
      case (func_r)
        EV_LOOP_BEGIN: begin
          nest_nxt = nest_r + LEVEL_BITS'(1);
          if (cmd.sample) begin
            watched_nxt = nest_r + LEVEL_BITS'(1);
          end
        end
        EV_LOOP_END: begin
          nest_nxt = nest_r - LEVEL_BITS'(1);
          if (cmd.sample) begin
            watched_nxt = '1;
          end
        end
        EV_ITER_BEGIN: begin
          if (at_watched) begin
            if (counter_r != '1) begin
              counter_nxt = counter_r + COUNT_BITS'(1);
            end
            if (!start_ok) begin
              start_nxt = value_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.sample) begin
      counter_nxt   = '0;
      start_nxt     = '1;
      last_time_nxt = ts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nest_r      <= '0;
      watched_r   <= '1;
      counter_r   <= '0;
      start_r     <= '1;
      last_time_r <= '0;
    end else begin
      nest_r      <= nest_nxt;
      watched_r   <= watched_nxt;
      counter_r   <= counter_nxt;
      start_r     <= start_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r   <= ev_t'(in_func);
      target_r <= in_is_target;
      value_r  <= in_iteration_value;
      ts_r     <= in_timestamp;
    end
  end

  // Restoring remainder of the count by the iteration period, one bit a cycle.
  assign div_shift = {rem_r, quo_r[COUNT_BITS-1]};
  assign div_diff  = div_shift - {1'b0, iter_period_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r     <= '0;
      quo_r     <= counter_r;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[COUNT_BITS-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + DIV_CNT_BITS'(1);
      if (!div_diff[PERIOD_BITS]) begin
        rem_r <= div_diff[PERIOD_BITS-1:0];
      end else begin
        rem_r <= div_shift[PERIOD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      out_count_r <= counter_r;
      out_first_r <= start_ok ? start_r : '0;
      out_has_r   <= start_ok;
    end
  end

  always_comb begin
    status.func       = func_r;
    status.at_watched = at_watched;
    status.begin_fire = watched_r[LEVEL_BITS-1] & target_r;
    status.time_fire  = (time_period_r != '0) &&
                        (elapsed > {{(TIME_BITS-TICKS_BITS){1'b0}}, time_period_r});
    status.period_on  = (iter_period_r != '0);
    status.div_last   = (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
    status.rem_zero   = (rem_r == '0);
  end

  assign out_iteration_count = out_count_r;
  assign out_first_iteration = out_first_r;
  assign out_has_first       = out_has_r;

endmodule
`default_nettype wire

>>> rtl/loop_sample_trigger.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// loop_sample_trigger
// Turns loop and iteration events into samples of iteration count and first
// iteration number.
//
// A request on the in_ channel carries one event with its timestamp. A result
// on the out_ channel carries one sample; an event causes at most one.
// The block works on one request at a time and holds in_stall high meanwhile.
// A request is evaluated in the cycle after it is taken; an event without
// a sample then returns to idle. A loop begin or loop end that samples, or
// an iteration end whose elapsed time is over the limit, goes on to the fire
// state, which loads the result register once that register can take it. An
// iteration end that checks the iteration period runs a bit-serial remainder
// of the count, one bit per cycle, then samples only if the remainder is zero.
// Results wait in an output register, so the next request is taken while a
// result is stalled; only a second sample waits for that register to drain.
// Configuration writes on cfg_ take effect at the next edge. The user makes
// them while the block is idle; the block does not enforce it. Reset clears
// the levels, count and timers, leaves no loop watched, needs no clearing pass.
// ----------------------------------------------------------------------------
module loop_sample_trigger
  import lst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_BITS-1:0]    cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_func,
  input  wire logic                   in_is_target,
  input  wire logic signed [ITER_BITS-1:0] in_iteration_value,
  input  wire logic [TIME_BITS-1:0]   in_timestamp,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COUNT_BITS-1:0]       out_iteration_count,
  output logic signed [ITER_BITS-1:0] out_first_iteration,
  output logic                        out_has_first
);

  cmd_t    cmd;
  status_t status;

  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lst_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_is_target        (in_is_target),
    .in_iteration_value  (in_iteration_value),
    .in_timestamp        (in_timestamp),
    .cmd                 (cmd),
    .status              (status),
    .out_iteration_count (out_iteration_count),
    .out_first_iteration (out_first_iteration),
    .out_has_first       (out_has_first)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sample |-> (!out_valid || !out_stall))
    else $error("sample loaded over a pending result");

  a_sample_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sample |=> out_valid)
    else $error("sample not presented");

  a_div_cause: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (status.func == EV_ITER_END && status.at_watched &&
                       status.period_on && !status.time_fire))
    else $error("remainder started for a wrong event");

endmodule
`default_nettype wire
